// File: design/pptv_pkg.sv
package pptv_pkg;

	// command codes
	localparam logic [2:0] FN_MOVE     = 3'd0;
	localparam logic [2:0] FN_PEN_DOWN = 3'd1;
	localparam logic [2:0] FN_PEN_UP   = 3'd2;
	localparam logic [2:0] FN_FRAME    = 3'd3;
	localparam logic [2:0] FN_COLOUR   = 3'd4;
	localparam logic [2:0] FN_END      = 3'd5;

	localparam logic [9:0] X_LIMIT = 10'd1023;
	localparam logic [9:0] Y_LIMIT = 10'd779;

	localparam logic [7:0] BYTE_VECTOR = 8'h1D;
	localparam logic [7:0] BYTE_POINT  = 8'h1C;
	localparam logic [7:0] BYTE_ALPHA  = 8'h18;
	localparam logic [7:0] BYTE_ESC    = 8'h1B;
	localparam logic [7:0] BYTE_RESET  = 8'h63;

	// last index of the clear sequence, form feed included
	localparam logic [3:0] CLR_LAST = 4'd13;

	typedef struct packed {
		logic [2:0]  func;
		logic [15:0] x_thou;
		logic [15:0] y_thou;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_byte;
	} out_item_t;

	// classified command, coordinates already in pixels
	typedef struct packed {
		logic [2:0] func;
		logic [9:0] px;
		logic [9:0] py;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic [7:0] clear_byte(input logic [3:0] idx);
		logic [7:0] b;
		case (idx)
			4'd0:    b = 8'h18;
			4'd1:    b = 8'h1B;
			4'd2:    b = 8'h5B;
			4'd3:    b = 8'h3F;
			4'd4:    b = 8'h39;
			4'd5:    b = 8'h68;
			4'd6:    b = 8'h1B;
			4'd7:    b = 8'h5B;
			4'd8:    b = 8'h3F;
			4'd9:    b = 8'h35;
			4'd10:   b = 8'h6C;
			4'd11:   b = 8'h1D;
			4'd12:   b = 8'h1B;
			4'd13:   b = 8'h0C;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// File: design/pptv_front.sv
module pptv_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  pptv_pkg::in_item_t  cmd,
	output logic                cmd_stall,
	input  pptv_pkg::q_status_t q_status,
	output logic                push,
	output pptv_pkg::cmd_t      wr
);

	// px = floor((2048x + 7500) / 15000), py = floor((39y + 125) / 250)
	localparam logic [27:0] X_BIAS  = 28'd7500;
	localparam logic [27:0] X_DIV   = 28'd15000;
	localparam logic [42:0] X_RECIP = 43'd17895;	// floor(2^28 / 15000)
	localparam logic [21:0] Y_MUL   = 22'd39;
	localparam logic [21:0] Y_BIAS  = 22'd125;
	localparam logic [21:0] Y_DIV   = 22'd250;
	localparam logic [36:0] Y_RECIP = 37'd16777;	// floor(2^22 / 250)

	logic        adv;
	logic        keep;
	logic        v_s1, v_s2;
	logic [2:0]  func_s1, func_s2;
	logic [27:0] nx_s1, nx_s2;
	logic [21:0] ny_s1, ny_s2;
	logic [13:0] qx_s2, qy_s2;
	logic [42:0] prod_x;
	logic [36:0] prod_y;
	logic [27:0] rx;
	logic [21:0] ry;
	logic [13:0] qx, qy;

	assign adv       = !(v_s2 && q_status.full);
	assign cmd_stall = !adv;
	assign keep      = cmd.func inside {pptv_pkg::FN_MOVE, pptv_pkg::FN_PEN_DOWN,
		pptv_pkg::FN_PEN_UP, pptv_pkg::FN_FRAME, pptv_pkg::FN_END};

	assign prod_x = 43'(nx_s1) * X_RECIP;
	assign prod_y = 37'(ny_s1) * Y_RECIP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= cmd_valid && keep;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			func_s1 <= cmd.func;
			nx_s1   <= (28'(cmd.x_thou) << 11) + X_BIAS;
			ny_s1   <= 22'(cmd.y_thou) * Y_MUL + Y_BIAS;
			func_s2 <= func_s1;
			nx_s2   <= nx_s1;
			ny_s2   <= ny_s1;
			qx_s2   <= prod_x[41:28];
			qy_s2   <= prod_y[35:22];
		end
	end

	// estimate is exact or one short
	always_comb begin
		rx = nx_s2 - 28'(qx_s2) * X_DIV;
		ry = ny_s2 - 22'(qy_s2) * Y_DIV;
		qx = (rx >= X_DIV) ? qx_s2 + 14'd1 : qx_s2;
		qy = (ry >= Y_DIV) ? qy_s2 + 14'd1 : qy_s2;
	end

	assign push    = v_s2 && !q_status.full;
	assign wr.func = func_s2;
	assign wr.px   = (qx > 14'(pptv_pkg::X_LIMIT)) ? pptv_pkg::X_LIMIT : qx[9:0];
	assign wr.py   = (qy > 14'(pptv_pkg::Y_LIMIT)) ? pptv_pkg::Y_LIMIT : qy[9:0];

endmodule

// File: design/pptv_queue.sv
module pptv_queue #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  pptv_pkg::cmd_t      wr,
	input  logic                pop,
	output pptv_pkg::cmd_t      rd,
	output pptv_pkg::q_status_t q_status
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	pptv_pkg::cmd_t slot_q [DEPTH];
	logic [AW-1:0]  wptr_q, rptr_q;
	logic [CW-1:0]  count_q;

	assign rd             = slot_q[rptr_q];
	assign q_status.full  = (count_q == CW'(DEPTH));
	assign q_status.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wptr_q] <= wr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			if (pop)
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: design/pptv_back.sv
module pptv_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                quiet,
	input  pptv_pkg::cmd_t      rd,
	input  pptv_pkg::q_status_t q_status,
	output logic                pop,
	output logic                tx_valid,
	input  logic                tx_stall,
	output pptv_pkg::out_item_t tx
);

	localparam logic [1:0]  MODE_ALPHA   = 2'd0;
	localparam logic [1:0]  MODE_VECTOR  = 2'd1;
	localparam logic [1:0]  MODE_POINT   = 2'd2;
	localparam logic [5:0]  ADDR_UNKNOWN = 6'h3F;
	localparam logic [10:0] BEAM_LOST    = 11'h7FF;
	localparam logic [2:0]  TAG_HIGH     = 3'b001;
	localparam logic [2:0]  TAG_LOW_Y    = 3'b011;
	localparam logic [2:0]  TAG_LOW_X    = 3'b010;

	typedef enum logic [11:0] {
		ST_IDLE       = 12'b000000000001,
		ST_FLUSH_MODE = 12'b000000000010,
		ST_ADDR_HY    = 12'b000000000100,
		ST_ADDR_LY    = 12'b000000001000,
		ST_ADDR_HX    = 12'b000000010000,
		ST_ADDR_LX    = 12'b000000100000,
		ST_VEC        = 12'b000001000000,
		ST_CLR_MODE   = 12'b000010000000,
		ST_CLR_SEQ    = 12'b000100000000,
		ST_ALPHA      = 12'b001000000000,
		ST_ESC        = 12'b010000000000,
		ST_RESC       = 12'b100000000000
	} st_t;

	// what follows an address
	typedef enum logic [2:0] {
		PH_FLUSH = 3'b001,
		PH_FROM  = 3'b010,
		PH_TO    = 3'b100
	} ph_t;

	st_t         state_q, state_d;
	ph_t         phase_q, phase_d;
	logic [2:0]  c_func_q, c_func_d;
	logic [9:0]  c_px_q, c_px_d, c_py_q, c_py_d;
	logic [3:0]  cnt_q, cnt_d;
	logic [1:0]  mode_q, mode_d;
	logic [5:0]  shy_q, shy_d, sly_q, sly_d, shx_q, shx_d;
	logic [9:0]  pen_x_q, pen_x_d, pen_y_q, pen_y_d;
	logic [10:0] beam_x_q, beam_x_d, beam_y_q, beam_y_d;
	logic        pp_q, pp_d, pd_q, pd_d;

	logic        emit, done;
	logic [7:0]  ebyte;
	logic        step_en, s_room, o_free;
	logic        s_valid_q, s_last_q;
	logic [7:0]  s_byte_q;
	logic        push_o, push_last;
	logic [5:0]  hy6, ly6, hx6;
	logic        at_beam;

	assign hy6     = {1'b0, pen_y_q[9:5]};
	assign ly6     = {1'b0, pen_y_q[4:0]};
	assign hx6     = {1'b0, pen_x_q[9:5]};
	assign at_beam = ({1'b0, pen_x_q} == beam_x_q) && ({1'b0, pen_y_q} == beam_y_q);

	assign o_free  = !tx_valid || !tx_stall;
	assign s_room  = !s_valid_q || o_free;
	assign step_en = (state_q == ST_IDLE) ? (!q_status.empty && s_room) : s_room;
	assign pop     = step_en && (state_q == ST_IDLE);

	always_comb begin
		state_d  = state_q;
		phase_d  = phase_q;
		c_func_d = c_func_q;
		c_px_d   = c_px_q;
		c_py_d   = c_py_q;
		cnt_d    = cnt_q;
		mode_d   = mode_q;
		shy_d    = shy_q;
		sly_d    = sly_q;
		shx_d    = shx_q;
		pen_x_d  = pen_x_q;
		pen_y_d  = pen_y_q;
		beam_x_d = beam_x_q;
		beam_y_d = beam_y_q;
		pp_d     = pp_q;
		pd_d     = pd_q;
		emit     = 1'b0;
		ebyte    = pptv_pkg::BYTE_VECTOR;
		done     = 1'b0;

		case (state_q)
			ST_IDLE: begin
				c_func_d = rd.func;
				c_px_d   = rd.px;
				c_py_d   = rd.py;
				case (rd.func)
					pptv_pkg::FN_MOVE: begin
						if (!pd_q) begin
							if (pp_q) begin
								state_d = ST_FLUSH_MODE;
								phase_d = PH_FLUSH;
							end else begin
								pen_x_d = rd.px;
								pen_y_d = rd.py;
								done    = 1'b1;
							end
						end else if (mode_q != MODE_VECTOR || !at_beam) begin
							state_d = ST_VEC;
						end else begin
							pen_x_d  = rd.px;
							pen_y_d  = rd.py;
							beam_x_d = {1'b0, rd.px};
							beam_y_d = {1'b0, rd.py};
							pp_d     = 1'b0;
							state_d  = ST_ADDR_HY;
							phase_d  = PH_TO;
						end
					end
					pptv_pkg::FN_PEN_DOWN: begin
						pp_d = 1'b1;
						pd_d = 1'b1;
						done = 1'b1;
					end
					pptv_pkg::FN_PEN_UP: begin
						pd_d = 1'b0;
						done = 1'b1;
					end
					pptv_pkg::FN_FRAME, pptv_pkg::FN_END: begin
						if (pp_q) begin
							state_d = ST_FLUSH_MODE;
							phase_d = PH_FLUSH;
						end else if (rd.func == pptv_pkg::FN_END && quiet)
							state_d = ST_ALPHA;
						else
							state_d = ST_CLR_MODE;
					end
					default: done = 1'b1;
				endcase
			end
			ST_FLUSH_MODE: begin
				if (mode_q != MODE_POINT) begin
					emit   = 1'b1;
					ebyte  = pptv_pkg::BYTE_POINT;
					mode_d = MODE_POINT;
					shy_d  = ADDR_UNKNOWN;
					sly_d  = ADDR_UNKNOWN;
					shx_d  = ADDR_UNKNOWN;
				end
				state_d = ST_ADDR_HY;
			end
			ST_ADDR_HY: begin
				if (hy6 != shy_q) begin
					emit  = 1'b1;
					ebyte = {TAG_HIGH, pen_y_q[9:5]};
					shy_d = hy6;
				end
				state_d = ST_ADDR_LY;
			end
			ST_ADDR_LY: begin
				// low-y always goes with high-x
				if (hx6 != shx_q || ly6 != sly_q) begin
					emit  = 1'b1;
					ebyte = {TAG_LOW_Y, pen_y_q[4:0]};
					sly_d = ly6;
				end
				state_d = ST_ADDR_HX;
			end
			ST_ADDR_HX: begin
				if (hx6 != shx_q) begin
					emit  = 1'b1;
					ebyte = {TAG_HIGH, pen_x_q[9:5]};
					shx_d = hx6;
				end
				state_d = ST_ADDR_LX;
			end
			ST_ADDR_LX: begin
				emit  = 1'b1;
				ebyte = {TAG_LOW_X, pen_x_q[4:0]};
				case (phase_q)
					PH_FLUSH: begin
						beam_x_d = {1'b0, pen_x_q};
						beam_y_d = {1'b0, pen_y_q};
						pp_d     = 1'b0;
						if (c_func_q == pptv_pkg::FN_MOVE) begin
							pen_x_d = c_px_q;
							pen_y_d = c_py_q;
							done    = 1'b1;
							state_d = ST_IDLE;
						end else if (c_func_q == pptv_pkg::FN_END && quiet)
							state_d = ST_ALPHA;
						else
							state_d = ST_CLR_MODE;
					end
					PH_FROM: begin
						pen_x_d  = c_px_q;
						pen_y_d  = c_py_q;
						beam_x_d = {1'b0, c_px_q};
						beam_y_d = {1'b0, c_py_q};
						pp_d     = 1'b0;
						state_d  = ST_ADDR_HY;
						phase_d  = PH_TO;
					end
					default: begin
						done    = 1'b1;
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_VEC: begin
				// dark vector to the pen: always re-enters vector mode
				emit    = 1'b1;
				ebyte   = pptv_pkg::BYTE_VECTOR;
				mode_d  = MODE_VECTOR;
				shy_d   = ADDR_UNKNOWN;
				sly_d   = ADDR_UNKNOWN;
				shx_d   = ADDR_UNKNOWN;
				state_d = ST_ADDR_HY;
				phase_d = PH_FROM;
			end
			ST_CLR_MODE: begin
				if (mode_q != MODE_VECTOR) begin
					emit   = 1'b1;
					ebyte  = pptv_pkg::BYTE_VECTOR;
					mode_d = MODE_VECTOR;
					shy_d  = ADDR_UNKNOWN;
					sly_d  = ADDR_UNKNOWN;
					shx_d  = ADDR_UNKNOWN;
				end
				cnt_d   = '0;
				state_d = ST_CLR_SEQ;
			end
			ST_CLR_SEQ: begin
				emit  = 1'b1;
				ebyte = pptv_pkg::clear_byte(cnt_q);
				cnt_d = cnt_q + 4'd1;
				if (cnt_q == pptv_pkg::CLR_LAST) begin
					beam_x_d = BEAM_LOST;
					beam_y_d = BEAM_LOST;
					if (c_func_q == pptv_pkg::FN_FRAME) begin
						pen_x_d = '0;
						pen_y_d = '0;
						pd_d    = 1'b0;
						done    = 1'b1;
						state_d = ST_IDLE;
					end else
						state_d = ST_ALPHA;
				end
			end
			ST_ALPHA: begin
				if (mode_q != MODE_ALPHA) begin
					emit   = 1'b1;
					ebyte  = pptv_pkg::BYTE_ALPHA;
					mode_d = MODE_ALPHA;
				end
				if (quiet) begin
					done    = 1'b1;
					state_d = ST_IDLE;
				end else
					state_d = ST_ESC;
			end
			ST_ESC: begin
				emit    = 1'b1;
				ebyte   = pptv_pkg::BYTE_ESC;
				state_d = ST_RESC;
			end
			ST_RESC: begin
				emit    = 1'b1;
				ebyte   = pptv_pkg::BYTE_RESET;
				done    = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			phase_q  <= PH_TO;
			cnt_q    <= '0;
			mode_q   <= MODE_ALPHA;
			shy_q    <= '0;
			sly_q    <= '0;
			shx_q    <= '0;
			pen_x_q  <= '0;
			pen_y_q  <= '0;
			beam_x_q <= BEAM_LOST;
			beam_y_q <= BEAM_LOST;
			pp_q     <= 1'b0;
			pd_q     <= 1'b0;
		end else if (step_en) begin
			state_q  <= state_d;
			phase_q  <= phase_d;
			cnt_q    <= cnt_d;
			mode_q   <= mode_d;
			shy_q    <= shy_d;
			sly_q    <= sly_d;
			shx_q    <= shx_d;
			pen_x_q  <= pen_x_d;
			pen_y_q  <= pen_y_d;
			beam_x_q <= beam_x_d;
			beam_y_q <= beam_y_d;
			pp_q     <= pp_d;
			pd_q     <= pd_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			c_func_q <= c_func_d;
			c_px_q   <= c_px_d;
			c_py_q   <= c_py_d;
		end
	end

	// the newest byte waits in the hold stage until the next one, or the
	// end of its command, tells whether it is the last
	always_comb begin
		push_o    = 1'b0;
		push_last = 1'b0;
		if (step_en) begin
			if (emit) begin
				push_o    = s_valid_q;
				push_last = s_last_q;
			end else if (s_valid_q && (s_last_q || done)) begin
				push_o    = 1'b1;
				push_last = 1'b1;
			end
		end else if (s_valid_q && s_last_q && o_free) begin
			push_o    = 1'b1;
			push_last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_valid_q <= 1'b0;
			s_last_q  <= 1'b0;
			tx_valid  <= 1'b0;
		end else begin
			if (step_en && emit) begin
				s_valid_q <= 1'b1;
				s_last_q  <= done;
			end else if (push_o)
				s_valid_q <= 1'b0;
			if (push_o)
				tx_valid <= 1'b1;
			else if (!tx_stall)
				tx_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && emit)
			s_byte_q <= ebyte;
		if (push_o) begin
			tx.out_byte  <= s_byte_q;
			tx.last_byte <= push_last;
		end
	end

endmodule

// File: design/pen_plot_to_vector_terminal_encoder_core.sv
// Path: scaling stages, command queue, byte sequencer, hold stage, then the tx register.
// Throughput: two scaling stages feed a command queue; the byte sequencer then spends
// a dispatch step plus one step per state, at most one byte a cycle while tx_stall is low;
// a dark-vector stroke passes the address states twice, a continued one once.
// Reset (arst_n low, asynchronous): alpha mode, pen up at origin, beam lost, queue empty.
module pen_plot_to_vector_terminal_encoder_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  pptv_pkg::in_item_t  cmd,
	output logic                tx_valid,
	input  logic                tx_stall,
	output pptv_pkg::out_item_t tx,
	input  logic                cfg_wen,
	input  logic                cfg_wdata
);

	pptv_pkg::q_status_t q_status;
	pptv_pkg::cmd_t      q_wr, q_rd;
	logic                q_push, q_pop;
	logic                quiet_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			quiet_q <= 1'b0;
		else if (cfg_wen)
			quiet_q <= cfg_wdata;
	end

	pptv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_stall (cmd_stall),
		.q_status  (q_status),
		.push      (q_push),
		.wr        (q_wr)
	);

	pptv_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr       (q_wr),
		.pop      (q_pop),
		.rd       (q_rd),
		.q_status (q_status)
	);

	pptv_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.quiet    (quiet_q),
		.rd       (q_rd),
		.q_status (q_status),
		.pop      (q_pop),
		.tx_valid (tx_valid),
		.tx_stall (tx_stall),
		.tx       (tx)
	);

endmodule

// File: design/pptv_checker.sv
module pptv_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                cmd_valid,
	input logic                cmd_stall,
	input logic                tx_valid,
	input logic                tx_stall,
	input pptv_pkg::out_item_t tx
);

	logic       seen_q;
	logic [4:0] run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
			run_q  <= '0;
		end else begin
			if (cmd_valid && !cmd_stall)
				seen_q <= 1'b1;
			if (tx_valid && !tx_stall)
				run_q <= tx.last_byte ? 5'd0 : run_q + 5'd1;
		end
	end

	// a held byte stays put
	a_tx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && tx_stall |=> tx_valid && $stable(tx))
		else $error("tx item changed while stalled");

	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !tx_valid)
		else $error("tx valid straight after reset");

	a_no_unprompted: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid |-> seen_q)
		else $error("byte before any command");

	// no command yields more than 23 bytes
	a_run_length: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && run_q == 5'd22 |-> tx.last_byte)
		else $error("byte run without last marker");

endmodule

bind pen_plot_to_vector_terminal_encoder_core pptv_checker u_chk (.*);
